@@ hw/rtl/tct_pkg.sv @@
// ----------------------------------------------------------------------------
// tct_pkg: shared types and constants of the touch contact tracker
// Slot count, field widths, op and event codes, cell interface structs and
// the coordinate scaling and one-hot encoding helpers.
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam int MAX_CONTACTS = 32;
    localparam int SLOT_W       = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;

    localparam int OP_W       = 3;
    localparam int SEQ_W      = 32;
    localparam int IN_COORD_W = 16;
    localparam int TIME_MS_W  = 32;
    localparam int SCALE_W    = 4;
    localparam int KIND_W     = 4;
    localparam int PROD_W     = IN_COORD_W + SCALE_W;

    localparam int EV_W      = 3;
    localparam int ID_W      = 5;
    localparam int DEV_W     = 32;
    localparam int COORD_W   = 19;
    localparam int TIME_US_W = 42;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 120;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [COORD_W-1:0]  COORD_MAX = 19'h7FFFF;
    localparam logic [TIME_US_W-1:0] US_PER_MS = 42'd1000;
    localparam int                  KIND_SHIFT = 28;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd1;
    localparam logic [KIND_W-1:0]  KIND_RESET  = 4'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KIND  = 1'd1;

    // touch event kinds
    localparam logic [OP_W-1:0] OP_BEGIN  = 3'd0;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
    localparam logic [OP_W-1:0] OP_END    = 3'd2;
    localparam logic [OP_W-1:0] OP_CANCEL = 3'd3;
    localparam logic [OP_W-1:0] OP_OTHER  = 3'd4;
    localparam logic [OP_W-1:0] OP_GRAB   = 3'd5;

    // result event codes
    localparam logic [EV_W-1:0] EV_ADD    = 3'd0;
    localparam logic [EV_W-1:0] EV_DOWN   = 3'd1;
    localparam logic [EV_W-1:0] EV_MOVE   = 3'd2;
    localparam logic [EV_W-1:0] EV_UP     = 3'd3;
    localparam logic [EV_W-1:0] EV_CANCEL = 3'd4;
    localparam logic [EV_W-1:0] EV_REMOVE = 3'd5;
    localparam logic [EV_W-1:0] EV_NOFREE = 3'd6;

    // broadcast to every cell
    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } tct_bcast_t;

    // per-cell write commands
    typedef struct packed {
        logic wr_pos;
        logic alloc;
        logic clr_valid;
    } tct_cell_ctl_t;

    // prefix flags passed from cell to cell
    typedef struct packed {
        logic free_seen;
        logic valid_seen;
    } tct_chain_t;

    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               first_free;
        logic               first_valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } tct_cell_stat_t;

    function automatic logic [COORD_W-1:0] scale_coord(input logic [IN_COORD_W-1:0] v,
                                                       input logic [SCALE_W-1:0] f);
        logic [PROD_W-1:0] p;
        p = PROD_W'(v) * PROD_W'(f);
        return (p > PROD_W'(COORD_MAX)) ? COORD_MAX : p[COORD_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] onehot_index(input logic [MAX_CONTACTS-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            if (v[i]) begin
                r = r | SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/touch_contact_tracker.sv @@
// ----------------------------------------------------------------------------
// touch_contact_tracker: touch contact slot tracker
// Maps touch sequence numbers to contact slots and emits add, down, move, up,
// cancel and remove results.
// ----------------------------------------------------------------------------
// A touch request is taken in the idle state and then passes the lookup state,
// in which every slot cell compares its sequence number and the cell chain
// picks the lowest free slot, and then emits its results through the single
// output register, one result per cycle while m_tready does not stall it.
// Other touch on a known contact and an unknown op give no result. Grab
// broken emits a cancel and a remove for each active slot. A new request is
// taken only once all results of the last one are in the output register.
// A full table yields one no-free-slot result and leaves the slots unchanged.
// ----------------------------------------------------------------------------
module touch_contact_tracker
    import tct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // touch requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // seq_number, x_in, y_in, time_ms
    input  logic [OP_W-1:0]       s_tuser,  // op
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // contact_id, pointer_id, x_out, y_out, time_us
    output logic [EV_W-1:0]       m_tuser,  // event_code
    output logic                  m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_EMIT   = 4'b0100,
        ST_SWEEP  = 4'b1000
    } tct_state_t;

    tct_state_t state_reg, state_next;

    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;

    // captured request
    logic [OP_W-1:0]       op_reg, op_next;
    logic [SEQ_W-1:0]      seq_reg, seq_next;
    logic [IN_COORD_W-1:0] x_in_reg, x_in_next;
    logic [IN_COORD_W-1:0] y_in_reg, y_in_next;
    logic [TIME_MS_W-1:0]  time_ms_reg, time_ms_next;

    // planned results
    logic [COORD_W-1:0]   x_sc_reg, x_sc_next;
    logic [COORD_W-1:0]   y_sc_reg, y_sc_next;
    logic [TIME_US_W-1:0] t_us_reg, t_us_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 has_slot_reg, has_slot_next;
    logic [EV_W-1:0]      res_code_reg [3];
    logic [EV_W-1:0]      res_code_next [3];
    logic [1:0]           res_cnt_reg, res_cnt_next;
    logic [1:0]           res_idx_reg, res_idx_next;
    logic                 phase_reg, phase_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [EV_W-1:0]      out_code_reg, out_code_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic [DEV_W-1:0]     out_dev_reg, out_dev_next;
    logic [COORD_W-1:0]   out_x_reg, out_x_next;
    logic [COORD_W-1:0]   out_y_reg, out_y_next;
    logic [TIME_US_W-1:0] out_tus_reg, out_tus_next;
    logic                 out_last_reg, out_last_next;

    // cell row
    tct_bcast_t     bcast;
    tct_cell_ctl_t  cell_ctl  [MAX_CONTACTS];
    tct_cell_stat_t cell_stat [MAX_CONTACTS];
    tct_chain_t     chain     [MAX_CONTACTS+1];

    logic [MAX_CONTACTS-1:0] hit_vec, free_vec, fvalid_vec, valid_vec;
    logic [MAX_CONTACTS-1:0] wr_vec, alloc_vec, clr_vec;
    logic [COORD_W-1:0]      sw_x, sw_y;
    logic                    hit_any, free_any, valid_any, others_valid;
    logic [COORD_W-1:0]      x_sc, y_sc;

    // load port of the output register
    logic                 out_free;
    logic                 ld_en;
    logic [EV_W-1:0]      ld_code;
    logic [SLOT_W-1:0]    ld_slot;
    logic                 ld_has_slot;
    logic [COORD_W-1:0]   ld_x, ld_y;
    logic                 ld_last;

    // lookup decode
    logic                 is_new;
    logic [EV_W-1:0]      k0, k1;
    logic [1:0]           kn;

    assign x_sc = scale_coord(x_in_reg, scale_reg);
    assign y_sc = scale_coord(y_in_reg, scale_reg);

    assign bcast.seq = seq_reg;
    assign bcast.x   = x_sc;
    assign bcast.y   = y_sc;

    assign chain[0] = '0;

    for (genvar g = 0; g < MAX_CONTACTS; g++) begin : g_cell
        tct_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .bcast     (bcast),
            .ctl       (cell_ctl[g]),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .stat      (cell_stat[g])
        );
        assign hit_vec[g]    = cell_stat[g].hit;
        assign free_vec[g]   = cell_stat[g].first_free;
        assign fvalid_vec[g] = cell_stat[g].first_valid;
        assign valid_vec[g]  = cell_stat[g].valid;
        assign cell_ctl[g].wr_pos    = wr_vec[g];
        assign cell_ctl[g].alloc     = alloc_vec[g];
        assign cell_ctl[g].clr_valid = clr_vec[g];
    end

    assign hit_any      = |hit_vec;
    assign free_any     = chain[MAX_CONTACTS].free_seen;
    assign valid_any    = chain[MAX_CONTACTS].valid_seen;
    assign others_valid = |(valid_vec & ~fvalid_vec);

    always_comb begin
        sw_x = '0;
        sw_y = '0;
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            if (fvalid_vec[i]) begin
                sw_x = sw_x | cell_stat[i].x;
                sw_y = sw_y | cell_stat[i].y;
            end
        end
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    // result kinds per op, after an optional add
    assign is_new = !hit_any;
    always_comb begin
        k0 = EV_DOWN;
        k1 = EV_REMOVE;
        kn = 2'd0;
        case (op_reg)
            OP_BEGIN: begin
                k0 = EV_DOWN;
                kn = 2'd1;
            end
            OP_UPDATE: begin
                k0 = EV_MOVE;
                kn = 2'd1;
            end
            OP_END: begin
                k0 = EV_UP;
                kn = 2'd2;
            end
            OP_CANCEL: begin
                k0 = EV_CANCEL;
                kn = 2'd2;
            end
            default: begin
                kn = 2'd0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        scale_next    = scale_reg;
        kind_next     = kind_reg;
        op_next       = op_reg;
        seq_next      = seq_reg;
        x_in_next     = x_in_reg;
        y_in_next     = y_in_reg;
        time_ms_next  = time_ms_reg;
        x_sc_next     = x_sc_reg;
        y_sc_next     = y_sc_reg;
        t_us_next     = t_us_reg;
        slot_next     = slot_reg;
        has_slot_next = has_slot_reg;
        res_code_next = res_code_reg;
        res_cnt_next  = res_cnt_reg;
        res_idx_next  = res_idx_reg;
        phase_next    = phase_reg;
        wr_vec        = '0;
        alloc_vec     = '0;
        clr_vec       = '0;
        ld_en         = 1'b0;
        ld_code       = res_code_reg[res_idx_reg];
        ld_slot       = slot_reg;
        ld_has_slot   = has_slot_reg;
        ld_x          = x_sc_reg;
        ld_y          = y_sc_reg;
        ld_last       = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_SCALE: scale_next = cfg_data;
                REG_KIND:  kind_next  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next      = s_tuser;
                    seq_next     = s_tdata[31:0];
                    x_in_next    = s_tdata[47:32];
                    y_in_next    = s_tdata[63:48];
                    time_ms_next = s_tdata[95:64];
                    state_next   = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                t_us_next    = TIME_US_W'(time_ms_reg) * US_PER_MS;
                x_sc_next    = x_sc;
                y_sc_next    = y_sc;
                res_idx_next = 2'd0;
                phase_next   = 1'b0;
                if (op_reg == OP_GRAB) begin
                    state_next = ST_SWEEP;
                end else if (op_reg > OP_GRAB) begin
                    state_next = ST_IDLE;
                end else if (is_new && !free_any) begin
                    // table full: report and leave slots alone
                    has_slot_next    = 1'b0;
                    slot_next        = '0;
                    res_code_next[0] = EV_NOFREE;
                    res_cnt_next     = 2'd1;
                    state_next       = ST_EMIT;
                end else begin
                    has_slot_next = 1'b1;
                    slot_next     = is_new ? onehot_index(free_vec) : onehot_index(hit_vec);
                    wr_vec        = is_new ? free_vec : hit_vec;
                    alloc_vec     = is_new ? free_vec : '0;
                    if (op_reg == OP_END || op_reg == OP_CANCEL) begin
                        clr_vec = wr_vec;
                    end
                    if (is_new) begin
                        res_code_next[0] = EV_ADD;
                        res_code_next[1] = k0;
                        res_code_next[2] = k1;
                        res_cnt_next     = kn + 2'd1;
                    end else begin
                        res_code_next[0] = k0;
                        res_code_next[1] = k1;
                        res_code_next[2] = EV_REMOVE;
                        res_cnt_next     = kn;
                    end
                    state_next = (is_new || kn != 2'd0) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ld_en        = 1'b1;
                    ld_last      = (res_idx_reg == res_cnt_reg - 2'd1);
                    res_idx_next = res_idx_reg + 2'd1;
                    if (ld_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SWEEP: begin
                if (out_free) begin
                    if (valid_any) begin
                        ld_en       = 1'b1;
                        ld_code     = phase_reg ? EV_REMOVE : EV_CANCEL;
                        ld_slot     = onehot_index(fvalid_vec);
                        ld_has_slot = 1'b1;
                        ld_x        = sw_x;
                        ld_y        = sw_y;
                        ld_last     = phase_reg && !others_valid;
                        phase_next  = !phase_reg;
                        if (phase_reg) begin
                            clr_vec = fvalid_vec;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_code_next  = out_code_reg;
        out_id_next    = out_id_reg;
        out_dev_next   = out_dev_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_tus_next   = out_tus_reg;
        out_last_next  = out_last_reg;
        if (ld_en) begin
            out_valid_next = 1'b1;
            out_code_next  = ld_code;
            out_id_next    = ld_has_slot ? ID_W'(ld_slot) : '0;
            out_dev_next   = ld_has_slot
                           ? ((DEV_W'(kind_reg) << KIND_SHIFT) | DEV_W'(ld_slot)) : '0;
            out_x_next     = ld_x;
            out_y_next     = ld_y;
            out_tus_next   = t_us_reg;
            out_last_next  = ld_last;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scale_reg     <= SCALE_RESET;
            kind_reg      <= KIND_RESET;
            out_valid_reg <= 1'b0;
            res_cnt_reg   <= 2'd0;
            res_idx_reg   <= 2'd0;
            phase_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scale_reg     <= scale_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
            res_cnt_reg   <= res_cnt_next;
            res_idx_reg   <= res_idx_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        seq_reg       <= seq_next;
        x_in_reg      <= x_in_next;
        y_in_reg      <= y_in_next;
        time_ms_reg   <= time_ms_next;
        x_sc_reg      <= x_sc_next;
        y_sc_reg      <= y_sc_next;
        t_us_reg      <= t_us_next;
        slot_reg      <= slot_next;
        has_slot_reg  <= has_slot_next;
        res_code_reg  <= res_code_next;
        out_code_reg  <= out_code_next;
        out_id_reg    <= out_id_next;
        out_dev_reg   <= out_dev_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_tus_reg   <= out_tus_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_code_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - ID_W - DEV_W - 2*COORD_W - TIME_US_W){1'b0}},
                       out_tus_reg, out_y_reg, out_x_reg, out_dev_reg, out_id_reg};

endmodule

@@ hw/rtl/tct_cell.sv @@
// ----------------------------------------------------------------------------
// tct_cell: one contact slot
// Holds valid, sequence number and last position of a contact, compares the
// broadcast sequence number and extends the first-free / first-valid chain.
// ----------------------------------------------------------------------------
module tct_cell
    import tct_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  tct_bcast_t     bcast,
    input  tct_cell_ctl_t  ctl,
    input  tct_chain_t     chain_in,
    output tct_chain_t     chain_out,
    output tct_cell_stat_t stat
);

    logic               valid_reg, valid_next;
    logic [SEQ_W-1:0]   seq_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;

    always_comb begin
        valid_next = valid_reg;
        if (ctl.clr_valid) begin
            valid_next = 1'b0;
        end else if (ctl.alloc) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.alloc) begin
            seq_reg <= bcast.seq;
        end
        if (ctl.wr_pos) begin
            x_reg <= bcast.x;
            y_reg <= bcast.y;
        end
    end

    assign chain_out.free_seen  = chain_in.free_seen | ~valid_reg;
    assign chain_out.valid_seen = chain_in.valid_seen | valid_reg;

    assign stat.valid       = valid_reg;
    assign stat.hit         = valid_reg && (seq_reg == bcast.seq);
    assign stat.first_free  = ~valid_reg & ~chain_in.free_seen;
    assign stat.first_valid = valid_reg & ~chain_in.valid_seen;
    assign stat.x           = x_reg;
    assign stat.y           = y_reg;

endmodule

@@ hw/rtl/tct_checker.sv @@
// ----------------------------------------------------------------------------
// tct_checker: port-level checks of the touch contact tracker
// Watches the result channel for ordering and field rules of the events.
// ----------------------------------------------------------------------------
module tct_checker
    import tct_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [EV_W-1:0]       m_tuser,
    input logic                  m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // no-free-slot stands alone and carries no slot
    a_nofree: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_NOFREE |-> m_tlast && m_tdata[36:0] == '0)
        else $error("no-free-slot result malformed");

    // up and cancel are never marked last, as a remove follows; down and move close a request
    a_up_cancel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_UP || m_tuser == EV_CANCEL) |-> !m_tlast)
        else $error("up or cancel marked last");

    a_down_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_DOWN || m_tuser == EV_MOVE) |-> m_tlast)
        else $error("down or move not marked last");

    // device id low bits repeat the contact id
    a_dev_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != EV_NOFREE |-> m_tdata[9:5] == m_tdata[4:0]
                                             && m_tdata[32:10] == '0)
        else $error("device id does not match contact id");

endmodule

bind touch_contact_tracker tct_checker u_tct_checker (.*);

@@ tb/sv/touch_contact_tracker_tb.sv @@
// ----------------------------------------------------------------------------
// touch_contact_tracker_tb: self-checking bench for the touch contact tracker
// Streams touch requests into the block and predicts the add, down, move, up,
// cancel, remove and no-free-slot results from a slot table kept here. Every
// accepted result is checked field by field against the oldest prediction.
// Directed requests come first, then random contact lifecycles, stray events
// and table-fill bursts, over several scale and device-kind settings.
// ----------------------------------------------------------------------------
module touch_contact_tracker_tb;
    import tct_pkg::*;

    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   SETTLE_CYCLES  = 16;
    localparam logic [TIME_US_W-1:0] MS_TO_US       = 42'd1000;
    localparam int                   KIND_POS       = 28;
    localparam logic [COORD_W-1:0]   COORD_LIMIT    = 19'h7FFFF;

    typedef struct {
        logic [OP_W-1:0]       op;
        logic [SEQ_W-1:0]      seq;
        logic [IN_COORD_W-1:0] x;
        logic [IN_COORD_W-1:0] y;
        logic [TIME_MS_W-1:0]  t;
        logic                  wait_idle;  // hold off until all results are in
    } touch_req_t;

    typedef struct {
        logic [EV_W-1:0]      code;
        logic [ID_W-1:0]      id;
        logic [DEV_W-1:0]     dev;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [TIME_US_W-1:0] t;
        logic                 last;
    } touch_event_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [EV_W-1:0]       m_tuser;
    logic                  m_tlast;

    touch_contact_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predicted tracker state
    logic [SCALE_W-1:0] scale_reg = SCALE_RESET;
    logic [KIND_W-1:0]  kind_reg  = KIND_RESET;
    logic               slot_live [MAX_CONTACTS];
    logic [SEQ_W-1:0]   slot_seq  [MAX_CONTACTS];
    logic [COORD_W-1:0] slot_x    [MAX_CONTACTS];
    logic [COORD_W-1:0] slot_y    [MAX_CONTACTS];
    int                 next_free = 0;

    touch_req_t         pending_touches [$];
    touch_event_t       expected_events [$];
    logic [SEQ_W-1:0]   live_seqs [$];     // contacts the generator believes are open
    touch_req_t         cur_req;
    int                 touches_queued   = 0;
    int                 touches_accepted = 0;
    int                 mismatch_count   = 0;
    int                 idle_cycles      = 0;
    int                 send_idle_pct    = 0;
    int                 recv_idle_pct    = 0;

    initial begin
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            slot_live[i] = 1'b0;
        end
    end

    function automatic logic [COORD_W-1:0] scaled(input logic [IN_COORD_W-1:0] v);
        int p;
        p = int'(v) * int'(scale_reg);
        return (p > int'(COORD_LIMIT)) ? COORD_LIMIT : COORD_W'(p);
    endfunction

    function automatic void expect_event(input logic [EV_W-1:0] code, input int slot,
                                         input bit has_slot, input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y,
                                         input logic [TIME_US_W-1:0] t_us);
        touch_event_t e;
        e.code = code;
        e.id   = has_slot ? ID_W'(slot) : '0;
        e.dev  = has_slot ? ((DEV_W'(kind_reg) << KIND_POS) | DEV_W'(slot)) : '0;
        e.x    = x;
        e.y    = y;
        e.t    = t_us;
        e.last = 1'b0;
        expected_events.push_back(e);
    endfunction

    task automatic predict_touch(input touch_req_t r);
        logic [TIME_US_W-1:0] t_us;
        logic [COORD_W-1:0]   px;
        logic [COORD_W-1:0]   py;
        int                   slot;
        int                   n0;
        bit                   found;
        n0    = expected_events.size();
        t_us  = TIME_US_W'(r.t) * MS_TO_US;
        slot  = 0;
        found = 1'b0;
        if (r.op == OP_GRAB) begin
            for (int i = 0; i < MAX_CONTACTS; i++) begin
                if (slot_live[i]) begin
                    expect_event(EV_CANCEL, i, 1'b1, slot_x[i], slot_y[i], t_us);
                    expect_event(EV_REMOVE, i, 1'b1, slot_x[i], slot_y[i], t_us);
                    slot_live[i] = 1'b0;
                end
            end
            if (expected_events.size() > n0) begin
                next_free = 0;
            end
        end else if (r.op < OP_GRAB) begin
            px = scaled(r.x);
            py = scaled(r.y);
            for (int i = 0; i < MAX_CONTACTS; i++) begin
                if (!found && slot_live[i] && slot_seq[i] == r.seq) begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            if (!found) begin
                // search only from the lowest slot that may be free
                for (int i = next_free; i < MAX_CONTACTS; i++) begin
                    if (!found && !slot_live[i]) begin
                        slot  = i;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    next_free       = slot;
                    slot_live[slot] = 1'b1;
                    slot_seq[slot]  = r.seq;
                    expect_event(EV_ADD, slot, 1'b1, px, py, t_us);
                end else begin
                    expect_event(EV_NOFREE, 0, 1'b0, px, py, t_us);
                end
            end
            if (found) begin
                slot_x[slot] = px;
                slot_y[slot] = py;
                case (r.op)
                    OP_BEGIN:  expect_event(EV_DOWN, slot, 1'b1, px, py, t_us);
                    OP_UPDATE: expect_event(EV_MOVE, slot, 1'b1, px, py, t_us);
                    OP_END, OP_CANCEL: begin
                        expect_event((r.op == OP_END) ? EV_UP : EV_CANCEL, slot, 1'b1,
                                     px, py, t_us);
                        expect_event(EV_REMOVE, slot, 1'b1, px, py, t_us);
                        slot_live[slot] = 1'b0;
                        if (slot < next_free) begin
                            next_free = slot;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (expected_events.size() > n0) begin
            expected_events[expected_events.size() - 1].last = 1'b1;
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        touch_req_t nxt;
        logic       busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_touch(cur_req);
                touches_accepted++;
                busy = 1'b0;
            end
            if (!busy && pending_touches.size() > 0
                && !(pending_touches[0].wait_idle && expected_events.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_touches.pop_front();
                cur_req  <= nxt;
                s_tdata  <= {nxt.t, nxt.y, nxt.x, nxt.seq};
                s_tuser  <= nxt.op;
                s_tvalid <= 1'b1;
            end else if (!busy) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (mismatch_count < 10) begin
            $display("mismatch %s: expected %0h, got %0h", what, want, got);
        end
        mismatch_count++;
    endtask

    // result monitor
    always @(posedge aclk) begin
        touch_event_t got;
        touch_event_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.code = m_tuser;
                got.id   = m_tdata[4:0];
                got.dev  = m_tdata[36:5];
                got.x    = m_tdata[55:37];
                got.y    = m_tdata[74:56];
                got.t    = m_tdata[116:75];
                got.last = m_tlast;
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected result, event_code", '0, got.code);
                end else begin
                    want = expected_events.pop_front();
                    if (got.code !== want.code) report_mismatch("event_code", want.code, got.code);
                    if (got.id !== want.id)     report_mismatch("contact_id", want.id, got.id);
                    if (got.dev !== want.dev)   report_mismatch("pointer_id", want.dev, got.dev);
                    if (got.x !== want.x)       report_mismatch("x_out", want.x, got.x);
                    if (got.y !== want.y)       report_mismatch("y_out", want.y, got.y);
                    if (got.t !== want.t)       report_mismatch("time_us", want.t, got.t);
                    if (got.last !== want.last) report_mismatch("last", want.last, got.last);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL touch_contact_tracker");
                $finish;
            end
        end
    end

    task automatic add_touch(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                             input logic [IN_COORD_W-1:0] x, input logic [IN_COORD_W-1:0] y,
                             input logic [TIME_MS_W-1:0] t, input logic wait_idle);
        touch_req_t r;
        r.op        = op;
        r.seq       = seq;
        r.x         = x;
        r.y         = y;
        r.t         = t;
        r.wait_idle = wait_idle;
        pending_touches.push_back(r);
        touches_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_SCALE) begin
            scale_reg = val;
        end else if (idx == REG_KIND) begin
            kind_reg = val;
        end
    endtask

    task automatic wait_drained();
        while (touches_accepted != touches_queued || expected_events.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic queue_directed();
        add_touch(OP_BEGIN,  32'h0000_0000, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        add_touch(OP_UPDATE, 32'h0000_0000, 16'h0000, 16'hFFFF, 32'h0000_0000, 1'b0);
        add_touch(OP_OTHER,  32'h0000_0000, 16'h1234, 16'h5678, 32'h0000_0001, 1'b0);
        add_touch(OP_OTHER,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        add_touch(OP_BEGIN,  32'hFFFF_FFFF, 16'h0001, 16'h0002, 32'h0000_0003, 1'b0);
        add_touch(OP_END,    32'h0000_0000, 16'h00FF, 16'hFF00, 32'h0000_0004, 1'b0);
        add_touch(OP_UPDATE, 32'hA5A5_5A5A, 16'h5555, 16'hAAAA, 32'h5555_AAAA, 1'b0);
        add_touch(OP_CANCEL, 32'hFFFF_FFFF, 16'hAAAA, 16'h5555, 32'hAAAA_5555, 1'b0);
        add_touch(OP_END,    32'h0000_0001, 16'h0010, 16'h0020, 32'h0000_0010, 1'b0);
        add_touch(OP_CANCEL, 32'h0000_0002, 16'h0030, 16'h0040, 32'h0000_0020, 1'b0);
        add_touch(3'd6,      32'h0000_0000, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        add_touch(3'd7,      32'hA5A5_5A5A, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
        add_touch(OP_BEGIN,  32'h0000_0003, 16'h0800, 16'h0400, 32'h0000_0030, 1'b0);
        // releases both open contacts, then finds nothing to release
        add_touch(OP_GRAB,   32'h1357_9BDF, 16'hFFFF, 16'hFFFF, 32'h0000_0040, 1'b0);
        add_touch(OP_GRAB,   32'h0000_0003, 16'h0000, 16'h0000, 32'h0000_0050, 1'b0);
        add_touch(OP_BEGIN,  32'h8000_0000, 16'h8000, 16'h7FFF, 32'h8000_0000, 1'b0);
        add_touch(OP_OTHER,  32'h8000_0000, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 1'b0);
        add_touch(OP_GRAB,   32'h0000_0000, 16'h0000, 16'h0000, 32'h0000_0060, 1'b0);
        add_touch(OP_UPDATE, 32'h0F0F_F0F0, 16'h0000, 16'h0000, 32'h0000_0070, 1'b1);
        add_touch(OP_END,    32'h0F0F_F0F0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic queue_random_touches(input int count);
        logic [OP_W-1:0]  op;
        logic [SEQ_W-1:0] seq;
        int               pick;
        int               idx;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            seq  = $urandom();
            op   = OP_BEGIN;
            if (live_seqs.size() == 0 || pick < 25) begin
                live_seqs.push_back(seq);
            end else if (pick < 85) begin
                idx = $urandom_range(0, live_seqs.size() - 1);
                seq = live_seqs[idx];
                if (pick < 55) begin
                    op = OP_UPDATE;
                end else if (pick < 62) begin
                    op = OP_OTHER;
                end else begin
                    op = (pick < 76) ? OP_END : OP_CANCEL;
                    live_seqs.delete(idx);
                end
            end else if (pick < 89) begin
                op = OP_GRAB;
                live_seqs.delete();
            end else begin
                // stray event: any op, on a fresh or an open contact
                op = OP_W'($urandom_range(0, 7));
                if ($urandom_range(0, 1) && live_seqs.size() > 0) begin
                    seq = live_seqs[$urandom_range(0, live_seqs.size() - 1)];
                end
                if (op == OP_GRAB) begin
                    live_seqs.delete();
                end
            end
            add_touch(op, seq, IN_COORD_W'($urandom()), IN_COORD_W'($urandom()), $urandom(),
                      ($urandom_range(0, 39) == 0));
        end
    endtask

    // more begins than slots, so the table runs full
    task automatic queue_table_fill();
        logic [SEQ_W-1:0] first_seq;
        first_seq = $urandom();
        add_touch(OP_BEGIN, first_seq, IN_COORD_W'($urandom()), IN_COORD_W'($urandom()),
                  $urandom(), 1'b0);
        for (int k = 0; k < MAX_CONTACTS + 2; k++) begin
            add_touch(OP_BEGIN, $urandom(), IN_COORD_W'($urandom()), IN_COORD_W'($urandom()),
                      $urandom(), 1'b0);
        end
        add_touch(OP_UPDATE, first_seq, IN_COORD_W'($urandom()), IN_COORD_W'($urandom()),
                  $urandom(), 1'b0);
        add_touch(OP_GRAB, $urandom(), IN_COORD_W'($urandom()), IN_COORD_W'($urandom()),
                  $urandom(), 1'b0);
        live_seqs.delete();
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] scale_plan [6];
        logic [CFG_DATA_W-1:0] kind_plan  [6];
        scale_plan = '{4'd15, 4'd0, 4'd1, 4'd8, 4'd3, 4'd12};
        kind_plan  = '{4'd0, 4'd15, 4'd2, 4'd9, 4'd5, 4'd15};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 17;
                recv_idle_pct = 65;
            end else if (ph < 4) begin
                send_idle_pct = 65;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_SCALE, scale_plan[ph]);
            write_reg(REG_KIND, kind_plan[ph]);
            if (ph == 0) begin
                queue_directed();
            end else begin
                queue_random_touches(42);
                if (ph == 2 || ph == 4) begin
                    queue_table_fill();
                end
            end
            wait_drained();
            // ignored requests may still be in flight
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("PASS touch_contact_tracker");
        end else begin
            $display("FAIL touch_contact_tracker");
        end
        $finish;
    end

endmodule
